// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types for the positional list engine
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_GATHER = 3'b010,
        S_OUTPUT = 3'b100
    } state_t;

    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
        logic match;
    } cell_ctrl_t;

endpackage

// ===== rtl/positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// top level of the positional list engine: control, cell row and read tree
//
// Holds up to 64 signed 32-bit values in a row of cells addressed by one-based
// position. Each request word (insert, read or remove) gives one result word
// with the read value, a status (ok, invalid position, full) and the count
// afterwards. Insert and remove shift the cells from the given position upward
// in the cycle the word is accepted. One request is handled at a time: the
// accepting edge loads the first registered level of the read tree, the
// gather state loads the result register, and the output state offers the
// result word. The input is ready again in the cycle after the result leaves;
// a held result stalls the input until it leaves.
// Cell contents are not cleared by reset; only positions below the count are
// ever read.
module positional_list_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // operation [1:0], position [8:2], value [40:9], zero fill above
    input  logic [ple_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_value [31:0], status [33:32], count [40:34], zero fill above
    output logic [ple_pkg::OUT_W-1:0]   m_tdata
);

    ple_pkg::state_t                    state_reg, state_next;
    logic [ple_pkg::CNT_W-1:0]          length_reg, length_next;
    logic [ple_pkg::ST_W-1:0]           st_reg, st_next;
    logic [ple_pkg::DATA_W-1:0]         grp_reg  [ple_pkg::NGRP];
    logic [ple_pkg::DATA_W-1:0]         grp_next [ple_pkg::NGRP];
    logic [ple_pkg::DATA_W-1:0]         rd_out_reg, rd_out_next;
    logic [ple_pkg::ST_W-1:0]           st_out_reg;
    logic [ple_pkg::CNT_W-1:0]          cnt_out_reg;

    logic [ple_pkg::OP_W-1:0]           op_in;
    logic [ple_pkg::POS_W-1:0]          pos_in;
    logic [ple_pkg::DATA_W-1:0]         val_in;
    logic [ple_pkg::POS_W-1:0]          k_idx;
    logic [ple_pkg::POS_W:0]            pos_ext;
    logic [ple_pkg::POS_W:0]            len_ext;
    logic                               accept;
    logic                               pos_zero;
    logic                               ins_ok, rd_ok, rem_ok;

    logic [ple_pkg::DATA_W-1:0]         cell_value [ple_pkg::CAPACITY];
    logic [ple_pkg::DATA_W-1:0]         cell_read  [ple_pkg::CAPACITY];
    ple_pkg::cell_ctrl_t                cell_ctrl  [ple_pkg::CAPACITY];

    assign op_in   = s_tdata[1:0];
    assign pos_in  = s_tdata[8:2];
    assign val_in  = s_tdata[40:9];
    assign k_idx   = pos_in - ple_pkg::POS_W'(1);
    assign pos_ext = {1'b0, pos_in};
    assign len_ext = (ple_pkg::POS_W + 1)'(length_reg);

    assign s_tready = (state_reg == ple_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pos_zero = (pos_in == '0);

    // request decode and status
    always_comb
    begin
        ins_ok      = 1'b0;
        rd_ok       = 1'b0;
        rem_ok      = 1'b0;
        st_next     = ple_pkg::ST_OK;
        length_next = length_reg;
        case (op_in)
            ple_pkg::OP_INSERT:
            begin
                if (pos_zero || (pos_ext > len_ext + (ple_pkg::POS_W + 1)'(1)))
                begin
                    st_next = ple_pkg::ST_BADPOS;
                end
                else if (length_reg >= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
                begin
                    st_next = ple_pkg::ST_FULL;
                end
                else
                begin
                    ins_ok      = 1'b1;
                    length_next = length_reg + ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::OP_READ:
            begin
                if (pos_zero || (pos_ext > len_ext))
                begin
                    st_next = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            ple_pkg::OP_REMOVE:
            begin
                if (pos_zero || (pos_ext > len_ext))
                begin
                    st_next = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    rem_ok      = 1'b1;
                    length_next = length_reg - ple_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                st_next = ple_pkg::ST_BADPOS;
            end
        endcase
    end

    // cell row
    for (genvar i = 0; i < ple_pkg::CAPACITY; i++)
    begin : g_cell
        logic [ple_pkg::DATA_W-1:0] left_value;
        logic [ple_pkg::DATA_W-1:0] right_value;
        logic                       at_k;
        logic                       above_k;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_mid_l
            assign left_value = cell_value[i-1];
        end

        if (i == ple_pkg::CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_mid_r
            assign right_value = cell_value[i+1];
        end

        assign at_k    = (k_idx == ple_pkg::POS_W'(i));
        assign above_k = (ple_pkg::POS_W'(i) > k_idx);

        assign cell_ctrl[i].load_new   = accept && ins_ok && at_k;
        assign cell_ctrl[i].take_left  = accept && ins_ok && above_k;
        assign cell_ctrl[i].take_right = accept && rem_ok && (at_k || above_k);
        assign cell_ctrl[i].match      = rd_ok && at_k;

        ple_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .new_value   (val_in),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .read_word   (cell_read[i])
        );
    end

    // first level of the read tree
    always_comb
    begin
        for (int g = 0; g < ple_pkg::NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < ple_pkg::GRP; j++)
            begin
                if (g * ple_pkg::GRP + j < ple_pkg::CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | cell_read[g * ple_pkg::GRP + j];
                end
            end
        end
    end

    // second level of the read tree
    always_comb
    begin
        rd_out_next = '0;
        for (int g = 0; g < ple_pkg::NGRP; g++)
        begin
            rd_out_next = rd_out_next | grp_reg[g];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ple_pkg::S_GATHER;
                end
            end
            ple_pkg::S_GATHER:
            begin
                state_next = ple_pkg::S_OUTPUT;
            end
            ple_pkg::S_OUTPUT:
            begin
                if (m_tready)
                begin
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ple_pkg::S_IDLE;
            length_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                length_reg <= length_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg <= st_next;
            for (int g = 0; g < ple_pkg::NGRP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
        if (state_reg == ple_pkg::S_GATHER)
        begin
            rd_out_reg  <= rd_out_next;
            st_out_reg  <= st_reg;
            cnt_out_reg <= length_reg;
        end
    end

    assign m_tvalid = (state_reg == ple_pkg::S_OUTPUT);
    assign m_tdata  = {
        (ple_pkg::OUT_W - ple_pkg::DATA_W - ple_pkg::ST_W - ple_pkg::CNT_W)'(0),
        cnt_out_reg, st_out_reg, rd_out_reg
    };

endmodule

// ===== rtl/ple_cell.sv =====
`timescale 1ns / 1ps
// one storage cell of the shifting list row
module ple_cell (
    input  logic                        clk,
    input  ple_pkg::cell_ctrl_t         ctrl,
    input  logic [ple_pkg::DATA_W-1:0]  new_value,
    input  logic [ple_pkg::DATA_W-1:0]  left_value,
    input  logic [ple_pkg::DATA_W-1:0]  right_value,
    output logic [ple_pkg::DATA_W-1:0]  value,
    output logic [ple_pkg::DATA_W-1:0]  read_word
);

    logic [ple_pkg::DATA_W-1:0] value_reg;
    logic [ple_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load_new)
        begin
            value_next = new_value;
        end
        else if (ctrl.take_left)
        begin
            value_next = left_value;
        end
        else if (ctrl.take_right)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign read_word = ctrl.match ? value_reg : '0;

endmodule
